// File: design/rms_pkg.sv
package rms_pkg;

    localparam logic [1:0] FUNC_REG   = 2'd0;
    localparam logic [1:0] FUNC_YIELD = 2'd1;
    localparam logic [1:0] FUNC_DEREG = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    localparam logic [1:0] MODE_SLEEP = 2'd0;
    localparam logic [1:0] MODE_READY = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] pid;
        logic [15:0] period;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic        running_valid;
        logic [14:0] running_pid;
    } rsp_t;

    typedef struct packed {
        logic        armed;
        logic [14:0] pid;
        logic [15:0] period;
        logic [31:0] deadline;
        logic [1:0]  mode;
    } entry_t;

endpackage

// File: design/rms_div.sv
module rms_div
    import rms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[15:0], q_reg[31]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done     = busy_reg && (cnt_reg == 6'd1);
    assign quotient = q_next;

endmodule

// File: design/rate_monotonic_task_scheduler.sv
// a request walks table entries in the scan, in the register shift and in the dispatch search
// as its function needs, and a late yield also waits for the divider's quotient
// throughput: one word at a time; busy stays high until the result strobe
// the result is shown for one cycle on result_valid; the receiver cannot stall
// reset clears the entry count, selection and time; the table body is not cleared
module rate_monotonic_task_scheduler
    import rms_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic result_valid,
    output rsp_t result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SCAN   = 12'b000000000010,
        S_SCANW  = 12'b000000000100,
        S_SHIFT  = 12'b000000001000,
        S_SHIFTW = 12'b000000010000,
        S_DIV    = 12'b000000100000,
        S_DSP    = 12'b000001000000,
        S_DSPW   = 12'b000010000000,
        S_DCUR   = 12'b000100000000,
        S_DCURW  = 12'b001000000000,
        S_DONE   = 12'b010000000000,
        S_DRUN   = 12'b100000000000
    } state_t;

    entry_t mem [MAX_TASKS];
    entry_t rd_reg;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    entry_t        wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] w_reg, w_next;
    logic          cur_v_reg, cur_v_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [14:0]   cpid_reg, cpid_next;
    logic [31:0]   now_reg, now_next;
    logic          ok_reg, ok_next;
    logic          fired_reg, fired_next;
    logic          found_reg, found_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic [14:0]   ppid_reg, ppid_next;
    logic [15:0]   pper_reg, pper_next;
    entry_t        hold_reg, hold_next;
    logic          rv_reg;
    rsp_t          res_reg;

    logic          div_start, div_done;
    logic [31:0]   div_q;
    logic [31:0]   late;

    assign late = now_reg - rd_reg.deadline;

    rms_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(late), .divisor(hold_reg.period),
        .done(div_done), .quotient(div_q)
    );

    function automatic logic [IW-1:0] ix(input logic [CW-1:0] v);
        logic [CW+IW-1:0] t;
        t = {{IW{1'b0}}, v};
        return t[IW-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        w_next     = w_reg;
        cur_v_next = cur_v_reg;
        cur_next   = cur_reg;
        cpid_next  = cpid_reg;
        now_next   = now_reg;
        ok_next    = ok_reg;
        fired_next = fired_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        ppid_next  = ppid_reg;
        pper_next  = pper_reg;
        hold_next  = hold_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = rd_reg;
        raddr      = '0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    ok_next    = 1'b1;
                    fired_next = 1'b0;
                    found_next = 1'b0;
                    i_next     = '0;
                    w_next     = '0;
                    j_next     = cnt_reg;
                    if (req.func == FUNC_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                    if (req.func == FUNC_REG && cnt_reg == CW'(MAX_TASKS))
                    begin
                        ok_next    = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        if (req.func == FUNC_REG)
                        begin
                            state_next = S_SHIFT;
                        end
                        else if (req.func == FUNC_YIELD)
                        begin
                            ok_next    = 1'b0;
                            state_next = S_DONE;
                        end
                        else if (req.func == FUNC_DEREG && !cur_v_reg)
                        begin
                            state_next = S_DSP;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        raddr      = '0;
                        state_next = S_SCANW;
                    end
                end
            end
            S_SCAN:
            begin
                raddr      = ix(i_reg);
                state_next = S_SCANW;
            end
            S_SCANW:
            begin
                state_next = S_SCAN;
                i_next     = i_reg + CW'(1);
                case (req_reg.func)
                    FUNC_REG:
                    begin
                        if (rd_reg.period > ((req_reg.period == 16'd0) ? 16'd1
                                              : req_reg.period))
                        begin
                            w_next     = i_reg;
                            state_next = S_SHIFT;
                        end
                        else if (i_reg + CW'(1) == cnt_reg)
                        begin
                            w_next     = cnt_reg;
                            state_next = S_SHIFT;
                        end
                    end
                    FUNC_YIELD:
                    begin
                        if (rd_reg.pid == req_reg.pid)
                        begin
                            hold_next      = rd_reg;
                            hold_next.mode = MODE_SLEEP;
                            hold_next.armed = 1'b1;
                            w_next         = i_reg;
                            if (rd_reg.deadline == 32'd0)
                            begin
                                hold_next.deadline = now_reg + {16'd0, rd_reg.period};
                                we = 1'b1; waddr = ix(i_reg); wdata = hold_next;
                                state_next = S_DONE;
                            end
                            else if (now_reg < rd_reg.deadline)
                            begin
                                we = 1'b1; waddr = ix(i_reg); wdata = hold_next;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                hold_next.mode     = MODE_READY;
                                hold_next.deadline = late;
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        else if (i_reg + CW'(1) == cnt_reg)
                        begin
                            ok_next    = 1'b0;
                            state_next = S_DONE;
                        end
                    end
                    FUNC_DEREG:
                    begin
                        if (rd_reg.pid == req_reg.pid)
                        begin
                            if (cur_v_reg)
                            begin
                                if (cur_reg == ix(w_reg))
                                begin
                                    cur_v_next = 1'b0;
                                end
                                else if (cur_reg > ix(w_reg))
                                begin
                                    cur_next = cur_reg - IW'(1);
                                end
                            end
                        end
                        else
                        begin
                            we = 1'b1; waddr = ix(w_reg); wdata = rd_reg;
                            w_next = w_reg + CW'(1);
                        end
                        if (i_reg + CW'(1) == cnt_reg)
                        begin
                            cnt_next = (rd_reg.pid == req_reg.pid) ? w_reg
                                       : w_reg + CW'(1);
                            state_next = cur_v_next ? S_DONE : S_DSP;
                        end
                    end
                    default:
                    begin
                        if (rd_reg.armed && now_reg >= rd_reg.deadline)
                        begin
                            we = 1'b1; waddr = ix(i_reg); wdata = rd_reg;
                            wdata.mode     = MODE_READY;
                            wdata.deadline = rd_reg.deadline + {16'd0, rd_reg.period};
                            wdata.armed    = 1'b0;
                            fired_next     = 1'b1;
                        end
                        if (i_reg + CW'(1) == cnt_reg)
                        begin
                            state_next = (fired_next) ? S_DSP : S_DONE;
                        end
                    end
                endcase
                if (state_next == S_DSP)
                begin
                    i_next     = '0;
                    found_next = 1'b0;
                end
            end
            S_SHIFT:
            begin
                if (j_reg == w_reg)
                begin
                    we = 1'b1; waddr = ix(w_reg);
                    wdata.armed    = 1'b0;
                    wdata.pid      = req_reg.pid;
                    wdata.period   = (req_reg.period == 16'd0) ? 16'd1 : req_reg.period;
                    wdata.deadline = 32'd0;
                    wdata.mode     = MODE_SLEEP;
                    cnt_next = cnt_reg + CW'(1);
                    if (cur_v_reg && CW'(cur_reg) >= w_reg)
                    begin
                        cur_next = cur_reg + IW'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = ix(j_reg - CW'(1));
                    state_next = S_SHIFTW;
                end
            end
            S_SHIFTW:
            begin
                we = 1'b1; waddr = ix(j_reg); wdata = rd_reg;
                j_next     = j_reg - CW'(1);
                state_next = S_SHIFT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    hold_next.deadline = now_reg - hold_reg.deadline
                        + (div_q + 32'd1) * {16'd0, hold_reg.period};
                    we = 1'b1; waddr = ix(w_reg); wdata = hold_next;
                    i_next     = '0;
                    found_next = 1'b0;
                    state_next = S_DSP;
                end
            end
            S_DSP:
            begin
                if (i_reg == cnt_reg)
                begin
                    state_next = S_DCUR;
                end
                else
                begin
                    raddr      = ix(i_reg);
                    state_next = S_DSPW;
                end
            end
            S_DSPW:
            begin
                if (rd_reg.mode == MODE_READY)
                begin
                    found_next = 1'b1;
                    pick_next  = ix(i_reg);
                    ppid_next  = rd_reg.pid;
                    pper_next  = rd_reg.period;
                    hold_next  = rd_reg;
                    state_next = S_DCUR;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_DSP;
                end
            end
            S_DCUR:
            begin
                if (cur_v_reg)
                begin
                    raddr      = cur_reg;
                    state_next = S_DCURW;
                end
                else
                begin
                    cur_v_next = found_reg;
                    cur_next   = found_reg ? pick_reg : '0;
                    cpid_next  = ppid_reg;
                    state_next = found_reg ? S_DRUN : S_DONE;
                end
            end
            S_DCURW:
            begin
                state_next = S_DONE;
                if (!(found_reg && pper_reg > rd_reg.period))
                begin
                    if ((!found_reg || cur_reg != pick_reg) && rd_reg.mode == MODE_RUN)
                    begin
                        we = 1'b1; waddr = cur_reg; wdata = rd_reg;
                        wdata.mode = MODE_READY;
                    end
                    cur_v_next = found_reg;
                    cur_next   = found_reg ? pick_reg : '0;
                    cpid_next  = ppid_reg;
                    if (found_reg)
                    begin
                        state_next = S_DRUN;
                    end
                end
            end
            S_DRUN:
            begin
                we = 1'b1; waddr = pick_reg; wdata = hold_reg;
                wdata.mode = MODE_RUN;
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            cur_v_reg <= 1'b0;
            cur_reg   <= '0;
            now_reg   <= '0;
            rv_reg    <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cur_v_reg <= cur_v_next;
            cur_reg   <= cur_next;
            now_reg   <= now_next;
            i_reg     <= i_next;
            rv_reg    <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        j_reg     <= j_next;
        w_reg     <= w_next;
        cpid_reg  <= cpid_next;
        ok_reg    <= ok_next;
        fired_reg <= fired_next;
        found_reg <= found_next;
        pick_reg  <= pick_next;
        ppid_reg  <= ppid_next;
        pper_reg  <= pper_next;
        hold_reg  <= hold_next;
        if (state_reg == S_DONE)
        begin
            res_reg.ok            <= ok_reg;
            res_reg.running_valid <= cur_v_reg;
            res_reg.running_pid   <= cur_v_reg ? cpid_reg : 15'd0;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

// File: design/rms_checker.sv
module rms_checker
    import rms_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input rsp_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_result_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held two cycles");

    a_idle_pid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.running_valid) |-> (result.running_pid == 15'd0))
        else $error("pid shown with none running");

    a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid) |-> !busy)
        else $error("result while still busy");

endmodule

bind rate_monotonic_task_scheduler rms_checker u_rms_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result_valid(result_valid), .result(result)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rms_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic result_valid;
    rsp_t result;

    rate_monotonic_task_scheduler #(.MAX_TASKS(TABLE_DEPTH)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // scheduler shadow state
    logic        sh_valid [TABLE_DEPTH];
    logic [14:0] sh_pid [TABLE_DEPTH];
    logic [15:0] sh_period [TABLE_DEPTH];
    logic [31:0] sh_deadline [TABLE_DEPTH];
    logic [1:0]  sh_mode [TABLE_DEPTH];
    logic        sh_armed [TABLE_DEPTH];
    logic        sh_cur_valid;
    int          sh_cur;
    logic [31:0] sh_now;

    rsp_t expected_words [$];
    int   error_count;
    int   idle_cycles;
    int   send_idle_pct;

    function automatic int table_count();
        int n;
        n = 0;
        while (n < TABLE_DEPTH && sh_valid[n])
            n++;
        return n;
    endfunction

    function automatic void move_slot(int dst, int src);
        sh_valid[dst]    = sh_valid[src];
        sh_pid[dst]      = sh_pid[src];
        sh_period[dst]   = sh_period[src];
        sh_deadline[dst] = sh_deadline[src];
        sh_mode[dst]     = sh_mode[src];
        sh_armed[dst]    = sh_armed[src];
    endfunction

    function automatic void pick_task();
        int n;
        int pick;
        logic found;
        n = table_count();
        found = 1'b0;
        pick = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && sh_mode[i] == MODE_READY)
            begin
                found = 1'b1;
                pick = i;
            end
        end
        if (found && sh_cur_valid && sh_period[pick] > sh_period[sh_cur])
            return;
        if (found)
            sh_mode[pick] = MODE_RUN;
        if (sh_cur_valid && (!found || sh_cur != pick) && sh_mode[sh_cur] == MODE_RUN)
            sh_mode[sh_cur] = MODE_READY;
        sh_cur_valid = found;
        sh_cur = found ? pick : 0;
    endfunction

    function automatic rsp_t schedule_step(req_t r);
        rsp_t o;
        int n;
        int p;
        int i;
        logic [31:0] per;
        logic [31:0] late;
        logic fired;
        o.ok = 1'b1;
        n = table_count();
        case (r.func)
            FUNC_REG:
            begin
                if (n >= TABLE_DEPTH)
                    o.ok = 1'b0;
                else
                begin
                    p = n;
                    for (i = n - 1; i >= 0; i--)
                        if (sh_period[i] > ((r.period == 0) ? 16'd1 : r.period))
                            p = i;
                    for (i = n; i > p; i--)
                        move_slot(i, i - 1);
                    sh_valid[p]    = 1'b1;
                    sh_pid[p]      = r.pid;
                    sh_period[p]   = (r.period == 0) ? 16'd1 : r.period;
                    sh_deadline[p] = 32'd0;
                    sh_mode[p]     = MODE_SLEEP;
                    sh_armed[p]    = 1'b0;
                    if (sh_cur_valid && sh_cur >= p)
                        sh_cur++;
                end
            end
            FUNC_YIELD:
            begin
                i = 0;
                while (i < n && sh_pid[i] != r.pid)
                    i++;
                if (i >= n)
                    o.ok = 1'b0;
                else
                begin
                    per = {16'd0, sh_period[i]};
                    sh_mode[i] = MODE_SLEEP;
                    sh_armed[i] = 1'b1;
                    if (sh_deadline[i] == 0)
                        sh_deadline[i] = sh_now + per;
                    else if (sh_now >= sh_deadline[i])
                    begin
                        sh_mode[i] = MODE_READY;
                        late = sh_now - sh_deadline[i];
                        sh_deadline[i] = sh_deadline[i] + (late / per + 1) * per;
                        pick_task();
                    end
                end
            end
            FUNC_DEREG:
            begin
                i = 0;
                while (i < n)
                begin
                    if (sh_pid[i] == r.pid)
                    begin
                        for (int k = i; k + 1 < n; k++)
                            move_slot(k, k + 1);
                        sh_valid[n - 1] = 1'b0;
                        sh_armed[n - 1] = 1'b0;
                        if (sh_cur_valid)
                        begin
                            if (sh_cur == i)
                                sh_cur_valid = 1'b0;
                            else if (sh_cur > i)
                                sh_cur--;
                        end
                        n--;
                    end
                    else
                        i++;
                end
                if (!sh_cur_valid)
                    pick_task();
            end
            default:
            begin
                sh_now = sh_now + 1;
                fired = 1'b0;
                for (i = 0; i < n; i++)
                begin
                    if (sh_armed[i] && sh_now >= sh_deadline[i])
                    begin
                        sh_mode[i] = MODE_READY;
                        sh_deadline[i] = sh_deadline[i] + sh_period[i];
                        sh_armed[i] = 1'b0;
                        fired = 1'b1;
                    end
                end
                if (fired)
                    pick_task();
            end
        endcase
        o.running_valid = sh_cur_valid;
        o.running_pid = sh_cur_valid ? sh_pid[sh_cur] : 15'd0;
        return o;
    endfunction

    task automatic send_word(req_t r, logic has_fixed, rsp_t fixed);
        rsp_t predicted;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        predicted = schedule_step(r);
        if (has_fixed && predicted !== fixed)
        begin
            $display("%0t table row mismatch: expected %h actual %h", $time, fixed, predicted);
            error_count++;
        end
        expected_words.push_back(predicted);
        start <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles <= (start && !busy) || result_valid ? 0 : idle_cycles + 1;
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t unexpected word: expected none actual %h", $time, result);
                    error_count++;
                end
                else
                begin
                    rsp_t e;
                    e = expected_words.pop_front();
                    if (result.ok !== e.ok)
                    begin
                        $display("%0t ok: expected %b actual %b", $time, e.ok, result.ok);
                        error_count++;
                    end
                    if (result.running_valid !== e.running_valid)
                    begin
                        $display("%0t running_valid: expected %b actual %b", $time,
                            e.running_valid, result.running_valid);
                        error_count++;
                    end
                    if (result.running_pid !== e.running_pid)
                    begin
                        $display("%0t running_pid: expected %h actual %h", $time,
                            e.running_pid, result.running_pid);
                        error_count++;
                    end
                end
            end
            if (idle_cycles > STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic req_t mk(logic [1:0] f, logic [14:0] p, logic [15:0] per);
        req_t r;
        r.func = f;
        r.pid = p;
        r.period = per;
        return r;
    endfunction

    function automatic rsp_t rs(logic o, logic v, logic [14:0] p);
        rsp_t r;
        r.ok = o;
        r.running_valid = v;
        r.running_pid = p;
        return r;
    endfunction

    function automatic logic [14:0] any_pid();
        int n;
        n = table_count();
        if (n > 0 && $urandom_range(9, 0) < 8)
            return sh_pid[$urandom_range(n - 1, 0)];
        return $urandom_range(3, 0) == 0 ? 15'($urandom) : 15'($urandom_range(20, 1));
    endfunction

    function automatic logic [15:0] any_period();
        case ($urandom_range(9, 0))
            0: return 16'($urandom);
            1: return 16'd0;
            2: return 16'hffff;
            default: return 16'($urandom_range(12, 1));
        endcase
    endfunction

    req_t dir_req [$];
    rsp_t dir_rsp [$];
    logic dir_fixed [$];

    task automatic row(req_t r, logic f, rsp_t e);
        dir_req.push_back(r);
        dir_fixed.push_back(f);
        dir_rsp.push_back(e);
    endtask

    initial
    begin
        req_t r;
        int roll;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 26;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_armed[i] = 1'b0;
            sh_pid[i] = '0;
            sh_period[i] = '0;
            sh_deadline[i] = '0;
            sh_mode[i] = MODE_SLEEP;
        end
        sh_cur_valid = 1'b0;
        sh_cur = 0;
        sh_now = '0;

        row(mk(FUNC_TICK, 15'd0, 16'd0), 1'b1, rs(1'b1, 1'b0, 15'd0));
        row(mk(FUNC_YIELD, 15'd5, 16'd0), 1'b1, rs(1'b0, 1'b0, 15'd0));
        row(mk(FUNC_DEREG, 15'h7fff, 16'd0), 1'b1, rs(1'b1, 1'b0, 15'd0));
        row(mk(FUNC_REG, 15'h7fff, 16'hffff), 1'b1, rs(1'b1, 1'b0, 15'd0));
        row(mk(FUNC_REG, 15'd0, 16'd0), 1'b1, rs(1'b1, 1'b0, 15'd0));
        row(mk(FUNC_REG, 15'd3, 16'd2), 1'b1, rs(1'b1, 1'b0, 15'd0));
        row(mk(FUNC_REG, 15'd3, 16'd2), 1'b1, rs(1'b1, 1'b0, 15'd0));
        row(mk(FUNC_YIELD, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_YIELD, 15'd3, 16'd0), 1'b0, '0);
        row(mk(FUNC_TICK, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_TICK, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_YIELD, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_TICK, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_TICK, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_TICK, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_TICK, 15'd0, 16'd0), 1'b0, '0);
        row(mk(FUNC_YIELD, 15'd3, 16'd0), 1'b0, '0);
        row(mk(FUNC_YIELD, 15'h7fff, 16'd0), 1'b0, '0);
        row(mk(FUNC_DEREG, 15'd3, 16'd0), 1'b0, '0);
        for (int i = 0; i < 14; i++)
            row(mk(FUNC_REG, 15'(100 + i), 16'(i + 1)), 1'b0, '0);
        row(mk(FUNC_REG, 15'd9, 16'd1), 1'b1, rs(1'b0, 1'b1, 15'd0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < dir_req.size(); i++)
            send_word(dir_req[i], dir_fixed[i], dir_rsp[i]);
        while (expected_words.size() > 0)
            @(posedge clk);

        for (int i = 0; i < 1300; i++)
        begin
            if (i == 450)
                send_idle_pct = 45;
            if (i == 900)
                send_idle_pct = 0;
            if (i % 100 == 50)
                while (expected_words.size() > 0)
                    @(posedge clk);
            roll = $urandom_range(99, 0);
            if (roll < 18 + (table_count() < 4 ? 20 : 0))
                r = mk(FUNC_REG, any_pid(), any_period());
            else if (roll < 50)
                r = mk(FUNC_YIELD, any_pid(), 16'($urandom));
            else if (roll < 58)
                r = mk(FUNC_DEREG, any_pid(), 16'($urandom));
            else
                r = mk(FUNC_TICK, 15'($urandom), 16'($urandom));
            send_word(r, 1'b0, '0);
        end

        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
